/* hw/rtl/bfa_pkg.sv */
// bfa_pkg: shared types and constants of the bitmap frame allocator
// holds command, status and register codes, channel payload structs and word unit types
// no dependencies
package bfa_pkg;

	// map word geometry
	localparam int WORD_W = 16;
	localparam int BIT_W  = 4;
	localparam int CNT_W  = 5;

	// compare width that holds any 16-bit register value and any frame bound
	localparam int CMP_W = 17;

	// register data width
	localparam int REG_W = 16;

	// command codes
	localparam logic [1:0] CMD_INIT  = 2'd0;
	localparam logic [1:0] CMD_ALLOC = 2'd1;
	localparam logic [1:0] CMD_FREE  = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_OOM = 2'd1;
	localparam logic [1:0] ST_BAD = 2'd2;

	// register indexes
	localparam logic [1:0] REG_TOTAL     = 2'd0;
	localparam logic [1:0] REG_KERNEL    = 2'd1;
	localparam logic [1:0] REG_HEAP_LO   = 2'd2;
	localparam logic [1:0] REG_HEAP_HI   = 2'd3;

	// word unit operations
	typedef enum logic [1:0] {
		WOP_ZERO    = 2'd0,
		WOP_RESERVE = 2'd1,
		WOP_HEAD    = 2'd2,
		WOP_WRAP    = 2'd3
	} wop_t;

	// word unit result
	typedef struct packed {
		logic [WORD_W-1:0] mask;
		logic [CNT_W-1:0]  pc;
		logic              hit;
		logic [BIT_W-1:0]  idx;
	} wu_res_t;

	// channel payloads
	typedef struct packed {
		logic [1:0]  command;
		logic [14:0] frame_number;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [14:0] allocated_frame;
		logic [15:0] free_count;
		logic [15:0] used_count;
	} rsp_t;

	typedef struct packed {
		logic [1:0]       index;
		logic [REG_W-1:0] data;
	} cfg_t;

endpackage

/* hw/rtl/bfa_if.sv */
// bfa_if: valid/ready channel interfaces of the frame allocator
// command, response and register write channels
// depends on bfa_pkg
interface bfa_cmd_if;
	import bfa_pkg::*;
	logic valid;
	logic ready;
	cmd_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface bfa_rsp_if;
	import bfa_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface bfa_cfg_if;
	import bfa_pkg::*;
	logic valid;
	logic ready;
	cfg_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/bfa_map_mem.sv */
// bfa_map_mem: used-frame map storage, one write and one registered read port
// 16-bit words, one bit per frame
// depends on bfa_pkg
module bfa_map_mem #(
	parameter int WORDS = 2048,
	parameter int AW    = 11
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [bfa_pkg::WORD_W-1:0]    wr_data,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr,
	output logic [bfa_pkg::WORD_W-1:0]    rd_data
);
	import bfa_pkg::*;

	logic [WORD_W-1:0] mem [WORDS];
	logic [WORD_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hw/rtl/bfa_word_unit.sv */
// bfa_word_unit: shared per-word unit of the allocator
// builds range masks for one map word, finds the first candidate bit and counts mask bits
// depends on bfa_pkg
module bfa_word_unit #(
	parameter int AW = 11
) (
	input  bfa_pkg::wop_t              op,
	input  logic [AW-1:0]              addr,
	input  logic [AW+4:0]              lim0,
	input  logic [AW+4:0]              lim1,
	input  logic [AW+4:0]              lim2,
	input  logic [bfa_pkg::WORD_W-1:0] data,
	output bfa_pkg::wu_res_t           res
);
	import bfa_pkg::*;

	localparam int XW = AW + 5;

	logic [XW-1:0]     base;
	logic [WORD_W-1:0] lt0;
	logic [WORD_W-1:0] lt1;
	logic [WORD_W-1:0] lt2;
	logic [WORD_W-1:0] mask;
	logic              hit;
	logic [BIT_W-1:0]  idx;

	// bits b of the word whose frame base+b lies below lim
	function automatic logic [WORD_W-1:0] lt_mask(input logic [XW-1:0] lim,
			input logic [XW-1:0] b);
		logic [XW:0]       diff;
		logic [WORD_W-1:0] m;
		diff = {1'b0, lim} - {1'b0, b};
		if (diff[XW]) begin
			m = '0;
		end else if (|diff[XW-1:BIT_W]) begin
			m = '1;
		end else begin
			m = ~({WORD_W{1'b1}} << diff[BIT_W-1:0]);
		end
		return m;
	endfunction

	assign base = XW'({addr, {BIT_W{1'b0}}});
	assign lt0  = lt_mask(lim0, base);
	assign lt1  = lt_mask(lim1, base);
	assign lt2  = lt_mask(lim2, base);

	// candidate mask per operation
	always_comb begin
		unique case (op)
			WOP_ZERO:    mask = '0;
			WOP_RESERVE: mask = lt0 | (~lt1 & lt2);
			WOP_HEAD:    mask = ~data & lt0 & ~lt1;
			WOP_WRAP:    mask = ~data & lt0 & lt1;
			default:     mask = '0;
		endcase
	end

	// lowest set bit of the mask
	always_comb begin
		hit = 1'b0;
		idx = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (mask[b]) begin
				hit = 1'b1;
				idx = BIT_W'(b);
			end
		end
	end

	assign res.mask = mask;
	assign res.pc   = CNT_W'($countones(mask));
	assign res.hit  = hit;
	assign res.idx  = idx;

endmodule

/* hw/rtl/bitmap_frame_allocator_rover.sv */
// bitmap_frame_allocator_rover: page frame allocator with a used-bit map and a next-fit rover
// sequencer, counters and registers; uses bfa_map_mem and bfa_word_unit
// depends on bfa_pkg and bfa_if
//
//   channel  dir  payload                                           beat when
//   cmd      in   command, frame_number                             cmd.valid & cmd.ready
//   rsp      out  status, allocated_frame, free_count, used_count   rsp.valid & rsp.ready
//   cfg      in   index, data                                       cfg.valid & cfg.ready
//
// while scanning, the map is read one 16-bit word per cycle through the memory read port
// init sweeps every map word, then holds the result; free reads the word, then checks and clears
// allocate scans map words from the rover to the last word, then wraps from word zero to the rover
// after reset a clearing pass over all WORDS map words runs before the first command beat is taken
// a finished response waits in the output register; the next command is taken meanwhile
module bitmap_frame_allocator_rover #(
	parameter int MAX_FRAMES = 32768
) (
	input  logic          clk,
	input  logic          arst_n,
	bfa_cmd_if.sink       cmd,
	bfa_rsp_if.source     rsp,
	bfa_cfg_if.sink       cfg
);
	import bfa_pkg::*;

	// frames reachable with 16-bit frame registers
	localparam int MAP_FRAMES = (MAX_FRAMES < 65535) ? MAX_FRAMES : 65535;
	localparam int WORDS      = (MAP_FRAMES + WORD_W - 1) / WORD_W;
	localparam int AW         = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int XW         = AW + 5;
	localparam int FXW        = AW + 4;
	localparam int CW         = $clog2(MAX_FRAMES + 1);
	localparam int FREE_RST   = (MAX_FRAMES < 32768) ? MAX_FRAMES : 32768;

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_SWEEP    = 6'b000010,
		S_SCAN     = 6'b000100,
		S_FREE_RD  = 6'b001000,
		S_FREE_CHK = 6'b010000,
		S_HOLD     = 6'b100000
	} state_t;

	state_t            state_q;

	logic [REG_W-1:0]  total_q;
	logic [REG_W-1:0]  kernel_q;
	logic [REG_W-1:0]  heap_lo_q;
	logic [REG_W-1:0]  heap_hi_q;

	logic [CW-1:0]     free_q;
	logic [CW-1:0]     used_q;
	logic [FXW-1:0]    rover_q;

	logic              init_q;
	logic [AW-1:0]     sweep_addr_q;
	logic [XW-1:0]     start_q;
	logic [AW-1:0]     scan_addr_q;
	logic              pass_q;
	logic              issue_q;
	logic [FXW-1:0]    fn_q;

	logic              tag_valid_s1;
	logic [AW-1:0]     tag_addr_s1;
	logic              tag_pass_s1;
	logic              tag_last_s1;

	logic [1:0]        res_status_q;
	logic [14:0]       res_frame_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [XW-1:0]     tot;
	logic [XW-1:0]     k_clip;
	logic [XW-1:0]     hlo_clip;
	logic [XW-1:0]     hhi_clip;
	logic [XW-1:0]     start;
	logic [XW-1:0]     tot_m1;
	logic [AW-1:0]     last_w;
	logic [AW-1:0]     start_w;

	wop_t              wu_op;
	logic [AW-1:0]     wu_addr;
	logic [XW-1:0]     lim0;
	logic [XW-1:0]     lim1;
	logic [XW-1:0]     lim2;
	wu_res_t           wu;

	logic              mem_wr_en;
	logic [AW-1:0]     mem_wr_addr;
	logic [WORD_W-1:0] mem_wr_data;
	logic              mem_rd_en;
	logic [AW-1:0]     mem_rd_addr;
	logic [WORD_W-1:0] rd_data;

	logic [WORD_W-1:0] hit_bit;
	logic [FXW-1:0]    frame_hit;
	logic [XW-1:0]     frame_nx;
	logic [WORD_W-1:0] fn_bit;
	logic              fn_set;
	logic              cmd_beat;
	logic              scan_done;
	logic [CW-1:0]     used_acc;
	logic [CW-1:0]     free_take;
	logic [CW-1:0]     used_take;
	logic [CW-1:0]     free_give;
	logic [CW-1:0]     used_give;

	// clip a register value to the effective frame count
	function automatic logic [XW-1:0] clip(input logic [REG_W-1:0] v,
			input logic [XW-1:0] t);
		return (CMP_W'(v) > CMP_W'(t)) ? t : XW'(v);
	endfunction

	// effective frame count and clipped reservation bounds
	assign tot      = (total_q > REG_W'(MAP_FRAMES)) ? XW'(MAP_FRAMES) : XW'(total_q);
	assign k_clip   = clip(kernel_q, tot);
	assign hlo_clip = clip(heap_lo_q, tot);
	assign hhi_clip = clip(heap_hi_q, tot);

	// scan start and bounds
	assign start   = (CMP_W'(rover_q) < CMP_W'(tot)) ? XW'(rover_q) : '0;
	assign tot_m1  = tot - XW'(1);
	assign last_w  = tot_m1[AW+3:BIT_W];
	assign start_w = start_q[AW+3:BIT_W];

	assign cmd_beat  = cmd.valid & cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// word unit operand select
	always_comb begin
		if (state_q == S_SWEEP) begin
			wu_op   = init_q ? WOP_RESERVE : WOP_ZERO;
			wu_addr = sweep_addr_q;
			lim0    = k_clip;
			lim1    = hlo_clip;
			lim2    = hhi_clip;
		end else begin
			wu_op   = tag_pass_s1 ? WOP_WRAP : WOP_HEAD;
			wu_addr = tag_addr_s1;
			lim0    = tot;
			lim1    = start_q;
			lim2    = tot;
		end
	end

	bfa_word_unit #(
		.AW (AW)
	) u_word (
		.op   (wu_op),
		.addr (wu_addr),
		.lim0 (lim0),
		.lim1 (lim1),
		.lim2 (lim2),
		.data (rd_data),
		.res  (wu)
	);

	// hit and free bit helpers
	assign hit_bit   = WORD_W'(1) << wu.idx;
	assign frame_hit = {tag_addr_s1, wu.idx};
	assign frame_nx  = XW'(frame_hit) + XW'(1);
	assign fn_bit    = WORD_W'(1) << fn_q[BIT_W-1:0];
	assign fn_set    = |(rd_data & fn_bit);

	// scan ends on a hit or after the last word of the wrapped pass
	assign scan_done = tag_valid_s1 & (wu.hit | tag_last_s1);

	// counter updates; the take and give updates saturate at zero and MAX_FRAMES
	assign used_acc  = used_q + CW'(wu.pc);
	assign free_take = (free_q != '0) ? free_q - CW'(1) : free_q;
	assign used_take = (used_q != CW'(MAX_FRAMES)) ? used_q + CW'(1) : used_q;
	assign free_give = (free_q != CW'(MAX_FRAMES)) ? free_q + CW'(1) : free_q;
	assign used_give = (used_q != '0) ? used_q - CW'(1) : used_q;

	// map port control
	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = tag_addr_s1;
		mem_wr_data = rd_data | hit_bit;
		mem_rd_en   = 1'b0;
		mem_rd_addr = scan_addr_q;
		unique case (state_q)
			S_SWEEP: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = sweep_addr_q;
				mem_wr_data = wu.mask;
			end
			S_SCAN: begin
				mem_wr_en = tag_valid_s1 & wu.hit;
				mem_rd_en = issue_q;
			end
			S_FREE_RD: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = fn_q[FXW-1:BIT_W];
			end
			S_FREE_CHK: begin
				mem_wr_en   = fn_set;
				mem_wr_addr = fn_q[FXW-1:BIT_W];
				mem_wr_data = rd_data & ~fn_bit;
			end
			default: begin
				mem_wr_en = 1'b0;
			end
		endcase
	end

	bfa_map_mem #(
		.WORDS (WORDS),
		.AW    (AW)
	) u_map (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (rd_data)
	);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= REG_W'(32768);
			kernel_q  <= '0;
			heap_lo_q <= '0;
			heap_hi_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.payload.index)
				REG_TOTAL:   total_q   <= cfg.payload.data;
				REG_KERNEL:  kernel_q  <= cfg.payload.data;
				REG_HEAP_LO: heap_lo_q <= cfg.payload.data;
				REG_HEAP_HI: heap_hi_q <= cfg.payload.data;
				default:     total_q   <= total_q;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			free_q       <= CW'(FREE_RST);
			used_q       <= '0;
			rover_q      <= '0;
			init_q       <= 1'b0;
			sweep_addr_q <= '0;
			start_q      <= '0;
			scan_addr_q  <= '0;
			pass_q       <= 1'b0;
			issue_q      <= 1'b0;
			fn_q         <= '0;
			tag_valid_s1 <= 1'b0;
			tag_addr_s1  <= '0;
			tag_pass_s1  <= 1'b0;
			tag_last_s1  <= 1'b0;
			res_status_q <= ST_OK;
			res_frame_q  <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			// output register drains unless a new result is loaded below
			if (rsp_valid_q && rsp.ready && state_q != S_HOLD) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (cmd_beat) begin
						res_frame_q  <= '0;
						tag_valid_s1 <= 1'b0;
						unique case (cmd.payload.command)
							CMD_INIT: begin
								init_q       <= 1'b1;
								sweep_addr_q <= '0;
								used_q       <= '0;
								state_q      <= S_SWEEP;
							end
							CMD_ALLOC: begin
								if (tot == '0) begin
									res_status_q <= ST_OOM;
									state_q      <= S_HOLD;
								end else begin
									start_q     <= start;
									scan_addr_q <= start[AW+3:BIT_W];
									pass_q      <= 1'b0;
									issue_q     <= 1'b1;
									state_q     <= S_SCAN;
								end
							end
							CMD_FREE: begin
								if (CMP_W'(cmd.payload.frame_number) < CMP_W'(tot)) begin
									fn_q    <= FXW'(cmd.payload.frame_number);
									state_q <= S_FREE_RD;
								end else begin
									res_status_q <= ST_BAD;
									state_q      <= S_HOLD;
								end
							end
							default: begin
								res_status_q <= ST_BAD;
								state_q      <= S_HOLD;
							end
						endcase
					end
				end

				// write one map word per cycle, counting reserved frames during init
				S_SWEEP: begin
					if (init_q) begin
						used_q <= used_acc;
					end
					sweep_addr_q <= sweep_addr_q + AW'(1);
					if (sweep_addr_q == AW'(WORDS - 1)) begin
						if (init_q) begin
							free_q       <= CW'(tot) - used_acc;
							rover_q      <= '0;
							res_status_q <= ST_OK;
							state_q      <= S_HOLD;
						end else begin
							state_q <= S_IDLE;
						end
						init_q <= 1'b0;
					end
				end

				// issue word reads from the rover, check the previous word
				S_SCAN: begin
					tag_valid_s1 <= issue_q;
					tag_addr_s1  <= scan_addr_q;
					tag_pass_s1  <= pass_q;
					tag_last_s1  <= pass_q && (scan_addr_q == start_w);
					if (issue_q && !scan_done) begin
						if (!pass_q) begin
							if (scan_addr_q == last_w) begin
								scan_addr_q <= '0;
								pass_q      <= 1'b1;
							end else begin
								scan_addr_q <= scan_addr_q + AW'(1);
							end
						end else if (scan_addr_q == start_w) begin
							issue_q <= 1'b0;
						end else begin
							scan_addr_q <= scan_addr_q + AW'(1);
						end
					end
					if (tag_valid_s1 && wu.hit) begin
						free_q       <= free_take;
						used_q       <= used_take;
						rover_q      <= (CMP_W'(frame_nx) < CMP_W'(tot)) ?
							FXW'(frame_nx) : '0;
						res_status_q <= ST_OK;
						res_frame_q  <= 15'(frame_hit);
						issue_q      <= 1'b0;
						state_q      <= S_HOLD;
					end else if (tag_valid_s1 && tag_last_s1) begin
						res_status_q <= ST_OOM;
						issue_q      <= 1'b0;
						state_q      <= S_HOLD;
					end
				end

				S_FREE_RD: begin
					state_q <= S_FREE_CHK;
				end

				// clear the bit if it was used, else report a bad free
				S_FREE_CHK: begin
					if (fn_set) begin
						free_q <= free_give;
						used_q <= used_give;
						if (CMP_W'(fn_q) < CMP_W'(rover_q)) begin
							rover_q <= fn_q;
						end
						res_status_q <= ST_OK;
					end else begin
						res_status_q <= ST_BAD;
					end
					state_q <= S_HOLD;
				end

				// hand the result to the output register once it is free
				S_HOLD: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q           <= 1'b1;
						rsp_q.status          <= res_status_q;
						rsp_q.allocated_frame <= res_frame_q;
						rsp_q.free_count      <= 16'(free_q);
						rsp_q.used_count      <= 16'(used_q);
						state_q               <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// an accepted command always leaves idle
	a_cmd_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_beat |=> (state_q != S_IDLE))
		else $error("command beat did not start work");

	// an allocation hit only ever claims a frame that was free
	a_hit_was_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && tag_valid_s1 && wu.hit) |-> ((rd_data & hit_bit) == '0))
		else $error("allocation picked a used frame");

	// the map is never written while idle or holding a result
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_HOLD) |-> !mem_wr_en)
		else $error("map written outside a command");

	// counters stay within the managed range
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(free_q <= CW'(MAX_FRAMES)) && (used_q <= CW'(MAX_FRAMES)))
		else $error("frame counter out of range");

endmodule
